[rtl/rbaf_pkg.sv]
package rbaf_pkg;

	localparam int TUSER_W     = 3;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [2:0] {
		REQ_WRITE     = 3'd0,
		REQ_READ      = 3'd1,
		REQ_TIME      = 3'd2,
		REQ_TICK_1HZ  = 3'd3,
		REQ_TICK_16HZ = 3'd4
	} req_t;

	// register addresses; bank 1 reuses 2..5, 7 and 8 for the alarm and 10 for the 12/24 select
	localparam logic [3:0] RA_SEC_1   = 4'd0;
	localparam logic [3:0] RA_SEC_10  = 4'd1;
	localparam logic [3:0] RA_MIN_1   = 4'd2;
	localparam logic [3:0] RA_MIN_10  = 4'd3;
	localparam logic [3:0] RA_HOUR_1  = 4'd4;
	localparam logic [3:0] RA_HOUR_10 = 4'd5;
	localparam logic [3:0] RA_WDAY    = 4'd6;
	localparam logic [3:0] RA_DAY_1   = 4'd7;
	localparam logic [3:0] RA_DAY_10  = 4'd8;
	localparam logic [3:0] RA_MON_1   = 4'd9;
	localparam logic [3:0] RA_MON_10  = 4'd10;
	localparam logic [3:0] RA_YEAR_1  = 4'd11;
	localparam logic [3:0] RA_YEAR_10 = 4'd12;
	localparam logic [3:0] RA_CTRL    = 4'd13;
	localparam logic [3:0] RA_PULSE   = 4'd15;
	localparam logic [3:0] RA_SEL24   = RA_MON_10;

	localparam logic [7:0] SEL24_RST = 8'h01;
	localparam logic [7:0] CTRL_RST  = 8'h08;
	localparam logic [7:0] PULSE_RST = 8'h0c;

	localparam int BANK_BIT      = 0;
	localparam int ALARM_EN_BIT  = 2;
	localparam int OFF_1HZ_BIT   = 3;
	localparam int OFF_16HZ_BIT  = 2;

	typedef struct packed {
		req_t        req_type;
		logic [3:0]  addr;
		logic [7:0]  write_data;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       alarm_low;
		logic       pulse_low;
	} result_t;

	// register file contents after reset
	function automatic logic [7:0] rf_reset_val(input logic [3:0] a);
		logic [7:0] v;
		unique case (a)
			RA_SEL24: v = SEL24_RST;
			RA_CTRL:  v = CTRL_RST;
			RA_PULSE: v = PULSE_RST;
			default:  v = 8'd0;
		endcase
		return v;
	endfunction

	// x / 10 for x < 64 via reciprocal
	function automatic logic [2:0] div10_small(input logic [5:0] x);
		logic [10:0] p;
		p = {5'd0, x} * 11'd26;
		return p[10:8];
	endfunction

	function automatic logic [3:0] mod10_small(input logic [5:0] x);
		logic [5:0] q6;
		logic [5:0] t;
		q6 = {3'd0, div10_small(x)};
		t  = x - ((q6 << 3) + (q6 << 1));
		return t[3:0];
	endfunction

endpackage

[rtl/rbaf_core.sv]
module rbaf_core (
	input  logic              clk,
	input  logic              arst_n,
	input  rbaf_pkg::item_t   item,
	input  logic              fire,
	output rbaf_pkg::result_t result
);

	logic [7:0]  rf_q [16];
	logic [13:0] cur_year_q;
	logic [10:0] cur_ydiv_q;
	logic [3:0]  cur_month_q;
	logic [4:0]  cur_day_q;
	logic [2:0]  cur_wday_q;
	logic [4:0]  cur_hour_q;
	logic [5:0]  cur_min_q;
	logic [5:0]  cur_sec_q;
	logic        alarm_q, half1_q, half16_q, pulse_q;

	logic        bank1, h24, wr_en, match;
	logic [29:0] yprod;
	logic [10:0] ydiv_d;
	logic [23:0] qprod;
	logic [7:0]  qq;
	logic [13:0] y10, yunits_w;
	logic [10:0] qq10, ytens_w;
	logic [3:0]  yunits, ytens;
	logic [1:0]  leap_cnt;
	logic [4:0]  h12, hsel;
	logic [6:0]  am, ah, ad;
	logic [7:0]  rd_fmt, rd;
	logic        alarm_d, half1_d, half16_d, pulse_d;

	assign bank1 = rf_q[rbaf_pkg::RA_CTRL][rbaf_pkg::BANK_BIT];
	assign h24   = rf_q[rbaf_pkg::RA_SEL24][0];
	assign wr_en = fire && (item.req_type == rbaf_pkg::REQ_WRITE)
		&& ((item.addr >= rbaf_pkg::RA_CTRL) || bank1);

	// year / 10 is taken once at the time update, read path only needs one more step
	assign yprod  = {16'd0, item.year} * 30'd52429;
	assign ydiv_d = yprod[29:19];

	assign qprod    = {13'd0, cur_ydiv_q} * 24'd6554;
	assign qq       = qprod[23:16];
	assign y10      = {cur_ydiv_q, 3'b000} + {2'b00, cur_ydiv_q, 1'b0};
	assign yunits_w = cur_year_q - y10;
	assign yunits   = yunits_w[3:0];
	assign qq10     = {qq, 3'b000} + {2'b00, qq, 1'b0};
	assign ytens_w  = cur_ydiv_q - qq10;
	assign ytens    = ytens_w[3:0];

	// only candidate is the year rounded down to a multiple of four; it fails on
	// a century that is not a multiple of 400
	always_comb begin
		if (cur_year_q[1:0] == 2'd3) begin
			leap_cnt = 2'd3;
		end else if (ytens == 4'd0 && yunits == {2'b00, cur_year_q[1:0]}
				&& qq[1:0] != 2'd0) begin
			leap_cnt = 2'd3;
		end else begin
			leap_cnt = cur_year_q[1:0];
		end
	end

	assign h12  = (cur_hour_q >= 5'd24) ? cur_hour_q - 5'd24 :
		(cur_hour_q >= 5'd12) ? cur_hour_q - 5'd12 : cur_hour_q;
	assign hsel = h24 ? cur_hour_q : h12;

	always_comb begin
		rd_fmt = 8'd0;
		priority if (item.addr >= rbaf_pkg::RA_CTRL
				|| (bank1 && item.addr != rbaf_pkg::RA_YEAR_1)) begin
			rd_fmt = rf_q[item.addr];
		end else if (item.addr == rbaf_pkg::RA_YEAR_1) begin
			rd_fmt = bank1 ? {6'd0, leap_cnt} : {4'd0, yunits};
		end else begin
			unique case (item.addr)
				rbaf_pkg::RA_SEC_1:   rd_fmt = {4'd0, rbaf_pkg::mod10_small(cur_sec_q)};
				rbaf_pkg::RA_SEC_10:  rd_fmt = {5'd0, rbaf_pkg::div10_small(cur_sec_q)};
				rbaf_pkg::RA_MIN_1:   rd_fmt = {4'd0, rbaf_pkg::mod10_small(cur_min_q)};
				rbaf_pkg::RA_MIN_10:  rd_fmt = {5'd0, rbaf_pkg::div10_small(cur_min_q)};
				rbaf_pkg::RA_HOUR_1:  rd_fmt = {4'd0, rbaf_pkg::mod10_small({1'b0, hsel})};
				rbaf_pkg::RA_HOUR_10: begin
					rd_fmt = {5'd0, rbaf_pkg::div10_small({1'b0, hsel})};
					if (!h24 && cur_hour_q >= 5'd12) rd_fmt[1] = 1'b1;
				end
				rbaf_pkg::RA_WDAY:    rd_fmt = {5'd0, cur_wday_q};
				rbaf_pkg::RA_DAY_1:   rd_fmt = {4'd0, rbaf_pkg::mod10_small({1'b0, cur_day_q})};
				rbaf_pkg::RA_DAY_10:  rd_fmt = {5'd0, rbaf_pkg::div10_small({1'b0, cur_day_q})};
				rbaf_pkg::RA_MON_1:   rd_fmt = {4'd0, rbaf_pkg::mod10_small({2'b0, cur_month_q})};
				rbaf_pkg::RA_MON_10:  rd_fmt = {5'd0, rbaf_pkg::div10_small({2'b0, cur_month_q})};
				default:              rd_fmt = {4'd0, ytens};
			endcase
		end
	end

	// alarm compare values from the bank 1 registers
	assign am = 7'(rf_q[rbaf_pkg::RA_MIN_1][3:0])
		+ 7'(rf_q[rbaf_pkg::RA_MIN_10][2:0]) * 7'd10;
	assign ah = h24
		? 7'(rf_q[rbaf_pkg::RA_HOUR_1][3:0]) + 7'(rf_q[rbaf_pkg::RA_HOUR_10][1:0]) * 7'd10
		: 7'(rf_q[rbaf_pkg::RA_HOUR_1][3:0])
			+ (rf_q[rbaf_pkg::RA_HOUR_10][0] ? 7'd10 : 7'd0)
			+ (rf_q[rbaf_pkg::RA_HOUR_10][1] ? 7'd12 : 7'd0);
	assign ad = 7'(rf_q[rbaf_pkg::RA_DAY_1][3:0])
		+ 7'(rf_q[rbaf_pkg::RA_DAY_10][1:0]) * 7'd10;
	assign match = rf_q[rbaf_pkg::RA_CTRL][rbaf_pkg::ALARM_EN_BIT]
		&& am == {1'b0, item.minute} && ah == {2'b00, item.hour} && ad == {2'b00, item.day};

	always_comb begin
		rd       = 8'd0;
		alarm_d  = alarm_q;
		half1_d  = half1_q;
		half16_d = half16_q;
		pulse_d  = pulse_q;
		unique case (item.req_type)
			rbaf_pkg::REQ_WRITE: begin
			end
			rbaf_pkg::REQ_READ: begin
				rd = rd_fmt;
			end
			rbaf_pkg::REQ_TIME: begin
				alarm_d = match;
			end
			rbaf_pkg::REQ_TICK_1HZ: begin
				half1_d = ~half1_q;
				pulse_d = alarm_q
					| (~rf_q[rbaf_pkg::RA_PULSE][rbaf_pkg::OFF_1HZ_BIT] & half1_d)
					| (~rf_q[rbaf_pkg::RA_PULSE][rbaf_pkg::OFF_16HZ_BIT] & half16_q);
			end
			rbaf_pkg::REQ_TICK_16HZ: begin
				half16_d = ~half16_q;
				pulse_d  = alarm_q
					| (~rf_q[rbaf_pkg::RA_PULSE][rbaf_pkg::OFF_1HZ_BIT] & half1_q)
					| (~rf_q[rbaf_pkg::RA_PULSE][rbaf_pkg::OFF_16HZ_BIT] & half16_d);
			end
			default: begin
			end
		endcase
	end

	assign result.read_data = rd;
	assign result.alarm_low = alarm_d;
	assign result.pulse_low = pulse_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= rbaf_pkg::rf_reset_val(4'(i));
			cur_year_q  <= '0;
			cur_ydiv_q  <= '0;
			cur_month_q <= '0;
			cur_day_q   <= '0;
			cur_wday_q  <= '0;
			cur_hour_q  <= '0;
			cur_min_q   <= '0;
			cur_sec_q   <= '0;
			alarm_q     <= 1'b0;
			half1_q     <= 1'b0;
			half16_q    <= 1'b0;
			pulse_q     <= 1'b0;
		end else begin
			if (wr_en) rf_q[item.addr] <= item.write_data;
			if (fire && item.req_type == rbaf_pkg::REQ_TIME) begin
				cur_year_q  <= item.year;
				cur_ydiv_q  <= ydiv_d;
				cur_month_q <= item.month;
				cur_day_q   <= item.day;
				cur_wday_q  <= item.weekday;
				cur_hour_q  <= item.hour;
				cur_min_q   <= item.minute;
				cur_sec_q   <= item.second;
			end
			if (fire) begin
				alarm_q  <= alarm_d;
				half1_q  <= half1_d;
				half16_q <= half16_d;
				pulse_q  <= pulse_d;
			end
		end
	end

endmodule

[rtl/rtc_bcd_register_file_alarm.sv]
// Real-time clock register file with alarm and pulse lines, seen as a stream block.
// Input channel s_*: one item per request. s_tuser carries the request kind (write,
// read, time update, 1 Hz toggle, 16 Hz toggle); s_tdata carries address, write byte
// and the calendar time used by a time update.
// Output channel m_*: exactly one result per input item, in order: the read byte
// (zero for anything but a read) and the alarm and pulse line levels after the item.
// An item passes through two register stages (input register, result register) on
// its way to m_*. Throughput is one item per cycle while the receiver takes results;
// the register file and time state update in the same cycle the item leaves the
// input register, so back-to-back items see each other's effects.
// When the receiver stalls, the result holds on m_tdata, the input register still
// fills, and s_tready drops only once both stages hold an item.
// Reset clears both stages and loads the register file defaults (24-hour mode,
// alarm disabled, both clock outputs masked); time and line state start at zero.
module rtc_bcd_register_file_alarm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // req_type
	// addr, write_data, year, month, day, weekday, hour, minute, second, 1 pad bit
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data, alarm_low, pulse_low, 6 pad bits
);

	rbaf_pkg::item_t   item_s1;
	rbaf_pkg::result_t res_s2, res_d;
	logic              valid_s1, valid_s2, advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) valid_s2 <= 1'b1;
			else if (m_tready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type   <= rbaf_pkg::req_t'(s_tuser);
			item_s1.addr       <= s_tdata[3:0];
			item_s1.write_data <= s_tdata[11:4];
			item_s1.year       <= s_tdata[25:12];
			item_s1.month      <= s_tdata[29:26];
			item_s1.day        <= s_tdata[34:30];
			item_s1.weekday    <= s_tdata[37:35];
			item_s1.hour       <= s_tdata[42:38];
			item_s1.minute     <= s_tdata[48:43];
			item_s1.second     <= s_tdata[54:49];
		end
		if (advance) res_s2 <= res_d;
	end

	rbaf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (advance),
		.result (res_d)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.pulse_low, res_s2.alarm_low, res_s2.read_data};

endmodule

[rtl/rbaf_chk.sv]
module rbaf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input side only backs up when the output is full and stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

	// an accepted item reaches the output if the receiver takes the result ahead of it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("accepted item did not reach the output");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:10] == 6'd0)
		else $error("pad bits of result set");

endmodule

bind rtc_bcd_register_file_alarm rbaf_chk u_rbaf_chk (.*);

[verif/rtc_alarm_checker.sv]
`timescale 1ns / 1ps

module rtc_alarm_checker
	import rbaf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [2:0]  s_tuser,   // req_type
	// addr, write_data, year, month, day, weekday, hour, minute, second, 1 pad bit
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // read_data, alarm_low, pulse_low, 6 pad bits
	output int          mismatches,
	output int          pending
);

	logic [7:0]  regs [16];
	logic [13:0] yr;
	logic [3:0]  mon;
	logic [4:0]  dom;
	logic [2:0]  wday;
	logic [4:0]  hr;
	logic [5:0]  mins;
	logic [5:0]  secs;
	logic        alarm_q;
	logic        half1;
	logic        half16;
	logic        pulse_q;

	result_t replies [$];

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int unsigned years_since_leap(input int unsigned y);
		int unsigned v;
		for (int unsigned k = 0; k < 3; k++) begin
			if (y >= k) begin
				v = y - k;
				if (v % 4 == 0 && (v % 100 != 0 || v % 400 == 0))
					return k;
			end
		end
		return 3;
	endfunction

	function automatic logic [7:0] read_value(input logic [3:0] a);
		int unsigned h;
		int unsigned v;
		logic        bank1;
		logic        h24;
		bank1 = regs[RA_CTRL][BANK_BIT];
		h24   = regs[RA_SEL24][0];
		if (a >= RA_CTRL || (bank1 && a != RA_YEAR_1))
			return regs[a];
		h = h24 ? hr : hr % 12;
		case (a)
			RA_SEC_1:   v = secs % 10;
			RA_SEC_10:  v = secs / 10;
			RA_MIN_1:   v = mins % 10;
			RA_MIN_10:  v = mins / 10;
			RA_HOUR_1:  v = h % 10;
			RA_HOUR_10: v = h24 ? h / 10 : ((h / 10) | (hr < 12 ? 0 : 2));
			RA_WDAY:    v = wday;
			RA_DAY_1:   v = dom % 10;
			RA_DAY_10:  v = dom / 10;
			RA_MON_1:   v = mon % 10;
			RA_MON_10:  v = mon / 10;
			RA_YEAR_1:  v = bank1 ? years_since_leap(yr) : yr % 10;
			default:    v = (yr % 100) / 10;
		endcase
		return v[7:0];
	endfunction

	function automatic void refresh_pulse();
		pulse_q = alarm_q | (~regs[RA_PULSE][OFF_1HZ_BIT] & half1)
			| (~regs[RA_PULSE][OFF_16HZ_BIT] & half16);
	endfunction

	task automatic apply_item(input logic [2:0] kind, input logic [55:0] d);
		int unsigned am;
		int unsigned ah;
		int unsigned ad;
		result_t     r;
		r.read_data = '0;
		case (kind)
			REQ_WRITE: begin
				if (d[3:0] >= RA_CTRL || regs[RA_CTRL][BANK_BIT])
					regs[d[3:0]] = d[11:4];
			end
			REQ_READ: r.read_data = read_value(d[3:0]);
			REQ_TIME: begin
				yr   = d[25:12];
				mon  = d[29:26];
				dom  = d[34:30];
				wday = d[37:35];
				hr   = d[42:38];
				mins = d[48:43];
				secs = d[54:49];
				am = regs[RA_MIN_1][3:0] + regs[RA_MIN_10][2:0] * 10;
				if (regs[RA_SEL24][0])
					ah = regs[RA_HOUR_1][3:0] + regs[RA_HOUR_10][1:0] * 10;
				else
					ah = regs[RA_HOUR_1][3:0] + regs[RA_HOUR_10][0] * 10
						+ (regs[RA_HOUR_10][1] ? 12 : 0);
				ad = regs[RA_DAY_1][3:0] + regs[RA_DAY_10][1:0] * 10;
				alarm_q = regs[RA_CTRL][ALARM_EN_BIT] && am == mins && ah == hr && ad == dom;
			end
			REQ_TICK_1HZ: begin
				half1 = ~half1;
				refresh_pulse();
			end
			REQ_TICK_16HZ: begin
				half16 = ~half16;
				refresh_pulse();
			end
			default: ;
		endcase
		r.alarm_low = alarm_q;
		r.pulse_low = pulse_q;
		replies.push_back(r);
	endtask

	task automatic check_result(input logic [15:0] d);
		result_t want;
		if (replies.size() == 0) begin
			report($sformatf("result 0x%04h with no item outstanding", d));
			return;
		end
		want = replies.pop_front();
		if (d[7:0] !== want.read_data)
			report($sformatf("read_data 0x%02h, predicted 0x%02h", d[7:0], want.read_data));
		if (d[8] !== want.alarm_low)
			report($sformatf("alarm_low %b, predicted %b", d[8], want.alarm_low));
		if (d[9] !== want.pulse_low)
			report($sformatf("pulse_low %b, predicted %b", d[9], want.pulse_low));
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				regs[i] = '0;
			regs[RA_SEL24] = SEL24_RST;
			regs[RA_CTRL]  = CTRL_RST;
			regs[RA_PULSE] = PULSE_RST;
			yr = '0; mon = '0; dom = '0; wday = '0;
			hr = '0; mins = '0; secs = '0;
			alarm_q = 1'b0; half1 = 1'b0; half16 = 1'b0; pulse_q = 1'b0;
			replies.delete();
			pending = 0;
		end else begin
			// a result never belongs to the item taken at the same edge, so pop first
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				apply_item(s_tuser, s_tdata);
			pending = replies.size();
		end
	end

endmodule

[verif/tb_rtc_bcd_register_file_alarm.sv]
`timescale 1ns / 1ps

module tb_rtc_bcd_register_file_alarm;
	import rbaf_pkg::*;

	localparam logic [2:0] REQ_SPARE_5 = 3'd5;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 1000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [2:0]  s_tuser;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	int          mismatches;
	int          pending;

	int items_sent = 0;
	int burst_left = 0;

	rtc_bcd_register_file_alarm u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rtc_alarm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [55:0] pack_time(input logic [13:0] y, input logic [3:0] mo,
			input logic [4:0] d, input logic [2:0] dw, input logic [4:0] h,
			input logic [5:0] mi, input logic [5:0] s);
		return {1'b0, s, mi, h, dw, d, mo, y, 12'($urandom_range(0, 4095))};
	endfunction

	function automatic logic [55:0] noise_data();
		logic [55:0] d;
		d = 56'({$urandom, $urandom});
		d[55] = 1'b0;
		return d;
	endfunction

	task automatic send(input logic [2:0] kind, input logic [55:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic bus_write(input logic [3:0] a, input logic [7:0] b);
		logic [55:0] d;
		d = noise_data();
		d[3:0]  = a;
		d[11:4] = b;
		send(REQ_WRITE, d);
	endtask

	task automatic bus_read(input logic [3:0] a);
		logic [55:0] d;
		d = noise_data();
		d[3:0] = a;
		send(REQ_READ, d);
	endtask

	task automatic time_load(input logic [13:0] y, input logic [3:0] mo, input logic [4:0] d,
			input logic [2:0] dw, input logic [4:0] h, input logic [5:0] mi,
			input logic [5:0] s);
		send(REQ_TIME, pack_time(y, mo, d, dw, h, mi, s));
	endtask

	// hold the input idle until every outstanding item has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// program an alarm in bank 1, load a time that mostly hits it, then poke and read back
	task automatic alarm_scenario();
		logic [7:0] ctrl;
		logic [7:0] b;
		logic       h24;
		int         mi, hh, dd, h12, n;
		h24 = 1'($urandom_range(0, 1));
		mi  = $urandom_range(0, 59);
		hh  = $urandom_range(0, 23);
		dd  = $urandom_range(1, 31);
		h12 = hh % 12;
		ctrl = 8'($urandom);
		ctrl[BANK_BIT]     = 1'b1;
		ctrl[ALARM_EN_BIT] = ($urandom_range(0, 3) != 0);
		bus_write(RA_CTRL, ctrl);
		b = 8'($urandom);
		b[0] = h24;
		bus_write(RA_SEL24, b);
		if ($urandom_range(0, 9) != 0) begin
			b = 8'($urandom); b[3:0] = 4'(mi % 10);
			bus_write(RA_MIN_1, b);
		end
		b = 8'($urandom); b[2:0] = 3'(mi / 10);
		bus_write(RA_MIN_10, b);
		b = 8'($urandom); b[3:0] = 4'(h24 ? hh % 10 : h12 % 10);
		bus_write(RA_HOUR_1, b);
		b = 8'($urandom);
		if (h24)
			b[1:0] = 2'(hh / 10);
		else
			b[1:0] = {hh >= 12, h12 >= 10};
		if ($urandom_range(0, 9) != 0)
			bus_write(RA_HOUR_10, b);
		b = 8'($urandom); b[3:0] = 4'(dd % 10);
		bus_write(RA_DAY_1, b);
		b = 8'($urandom); b[1:0] = 2'(dd / 10);
		bus_write(RA_DAY_10, b);
		if ($urandom_range(0, 1))
			bus_write(RA_PULSE, 8'($urandom));
		case ($urandom_range(0, 9))
			0: mi = (mi + 1) % 60;
			1: hh = (hh + 1) % 24;
			2: dd = dd % 31 + 1;
			default: ;
		endcase
		time_load(14'($urandom_range(0, 9999)), 4'($urandom_range(1, 12)), 5'(dd),
			3'($urandom_range(0, 6)), 5'(hh), 6'(mi), 6'($urandom_range(0, 59)));
		n = $urandom_range(1, 6);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: send(REQ_TICK_1HZ, noise_data());
				1: send(REQ_TICK_16HZ, noise_data());
				default: bus_read(4'($urandom_range(0, 15)));
			endcase
		end
		if ($urandom_range(0, 9) < 7) begin
			ctrl[BANK_BIT] = 1'b0;
			bus_write(RA_CTRL, ctrl);
		end
		n = $urandom_range(3, 8);
		repeat (n) bus_read(4'($urandom_range(0, 15)));
	endtask

	task automatic random_item();
		case ($urandom_range(0, 4))
			REQ_WRITE: bus_write(4'($urandom_range(0, 15)), 8'($urandom));
			REQ_READ:  bus_read(4'($urandom_range(0, 15)));
			REQ_TIME:  time_load(14'($urandom_range(0, 9999)), 4'($urandom_range(1, 12)),
				5'($urandom_range(1, 31)), 3'($urandom_range(0, 6)),
				5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
				6'($urandom_range(0, 59)));
			REQ_TICK_1HZ: send(REQ_TICK_1HZ, noise_data());
			default:      send(REQ_TICK_16HZ, noise_data());
		endcase
	endtask

	// receiver: changing stall patterns plus a long hold-off now and then
	initial begin
		int  cyc;
		int  mode;
		logic rdy;
		cyc  = 0;
		mode = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 500 == 250) begin
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				cyc += 60;
			end else begin
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = (cyc % 8) < 2;
				endcase
				m_tready <= rdy;
			end
		end
	end

	initial begin
		int  random_start;
		bit  paused;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		paused   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then writes ignored while bank 0 is selected
		bus_read(RA_CTRL);
		bus_read(RA_PULSE);
		bus_read(RA_SEC_1);
		bus_write(RA_MIN_1, 8'hff);
		// bank 1 with alarm enabled: alarm at day 31, 23:59
		bus_write(RA_CTRL, 8'h0d);
		bus_write(RA_MIN_1, 8'h09);
		bus_write(RA_MIN_10, 8'h05);
		bus_write(RA_HOUR_1, 8'h03);
		bus_write(RA_HOUR_10, 8'h02);
		bus_write(RA_DAY_1, 8'h01);
		bus_write(RA_DAY_10, 8'h03);
		time_load(14'd9999, 4'd12, 5'd31, 3'd6, 5'd23, 6'd59, 6'd59);
		bus_read(RA_YEAR_1);
		bus_read(RA_MIN_1);
		// unmask both clocks, toggle each, then 12-hour mode and bank 0
		bus_write(RA_PULSE, 8'h00);
		send(REQ_TICK_1HZ, noise_data());
		send(REQ_TICK_16HZ, noise_data());
		bus_write(RA_SEL24, 8'h00);
		bus_write(RA_CTRL, 8'h04);
		bus_read(RA_HOUR_10);
		bus_read(RA_HOUR_1);
		// every time field at its width limit, but the day, which is zero
		time_load(14'h3fff, 4'hf, 5'd0, 3'd7, 5'd31, 6'd63, 6'd63);
		bus_read(RA_YEAR_10);
		bus_read(RA_SEC_10);
		send(REQ_SPARE_5, noise_data());
		send(REQ_SPARE_7, noise_data());
		drain();

		random_start = items_sent;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			if (!paused && items_sent >= random_start + RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: alarm_scenario();
				6, 7, 8: random_item();
				default: send(3'($urandom_range(0, 7)), noise_data());
			endcase
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
